// ===== hdl/isort_pkg.sv =====
package isort_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [1:0] RD_POS_M1 = 2'd0;
   localparam logic [1:0] RD_POS_M2 = 2'd1;
   localparam logic [1:0] RD_INDEX  = 2'd2;

   localparam logic WR_VALUE = 1'b0;
   localparam logic WR_SHIFT = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] value;
      logic [7:0]  index;
   } isort_req_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic [8:0]  stored_count;
      logic [1:0]  status;
   } isort_rsp_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       pos_dec;
      logic       cnt_inc;
      logic       cnt_clr;
      logic       rv_load;
      logic       st_we;
      logic [1:0] st_code;
   } isort_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       full;
      logic       cnt_zero;
      logic       pos_one;
      logic       greater;
      logic       idx_ok;
   } isort_stat_type;

endpackage

// ===== hdl/isort_ctrl.sv =====
module isort_ctrl
   import isort_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output logic           rsp_valid,
   input  isort_stat_type stat,
   output isort_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_PLACE  = 3'd3;
   localparam logic [2:0] ST_RWAIT  = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.command)
               CMD_INSERT: begin
                  if (stat.full) begin
                     cmd.st_we   = 1'b1;
                     cmd.st_code = STATUS_FULL;
                     state_in    = ST_RESP;
                  end else if (stat.cnt_zero) begin
                     state_in = ST_PLACE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS_M1;
                     state_in   = ST_SCAN;
                  end
               end
               CMD_READ: begin
                  if (stat.idx_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_INDEX;
                     state_in   = ST_RWAIT;
                  end else begin
                     cmd.st_we   = 1'b1;
                     cmd.st_code = STATUS_RANGE;
                     state_in    = ST_RESP;
                  end
               end
               CMD_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_RESP;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_SCAN: begin
            if (stat.greater) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_SHIFT;
               cmd.pos_dec = 1'b1;
               if (stat.pos_one) begin
                  state_in = ST_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_POS_M2;
               end
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_VALUE;
               cmd.cnt_inc = 1'b1;
               state_in    = ST_RESP;
            end
         end
         ST_PLACE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_VALUE;
            cmd.cnt_inc = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RWAIT: begin
            cmd.rv_load = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

// ===== hdl/isort_dp.sv =====
module isort_dp
   import isort_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int VALUE_BITS = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  isort_req_type  req_item,
   input  isort_cmd_type  cmd,
   output isort_stat_type stat,
   output isort_rsp_type  rsp_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [VALUE_BITS-1:0] mem [DEPTH];

   logic [1:0]            command_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [7:0]            idx_ff;
   logic [CW-1:0]         pos_ff;
   logic [CW-1:0]         cnt_ff;
   logic [VALUE_BITS-1:0] rd_ff;
   logic [VALUE_BITS-1:0] rv_ff;
   logic [1:0]            status_ff;

   logic [CW-1:0]         pos_m1;
   logic [CW-1:0]         pos_m2;
   logic [AW-1:0]         raddr;
   logic [AW-1:0]         waddr;
   logic [VALUE_BITS-1:0] wdata;

   assign pos_m1 = pos_ff - CW'(1);
   assign pos_m2 = pos_ff - CW'(2);
   assign waddr  = pos_ff[AW-1:0];
   assign wdata  = (cmd.wr_sel == WR_SHIFT) ? rd_ff : val_ff;

   always_comb begin
      case (cmd.rd_sel)
         RD_POS_M1: raddr = pos_m1[AW-1:0];
         RD_POS_M2: raddr = pos_m2[AW-1:0];
         RD_INDEX:  raddr = AW'(idx_ff);
         default:   raddr = pos_m1[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_item.command;
         val_ff     <= VALUE_BITS'(req_item.value);
         idx_ff     <= req_item.index;
         pos_ff     <= cnt_ff;
         rv_ff      <= '0;
         status_ff  <= STATUS_OK;
      end else begin
         if (cmd.pos_dec) begin
            pos_ff <= pos_m1;
         end
         if (cmd.rv_load) begin
            rv_ff <= rd_ff;
         end
         if (cmd.st_we) begin
            status_ff <= cmd.st_code;
         end
      end
   end

   assign stat.command  = command_ff;
   assign stat.full     = (cnt_ff == CW'(DEPTH));
   assign stat.cnt_zero = (cnt_ff == '0);
   assign stat.pos_one  = (pos_ff == CW'(1));
   assign stat.greater  = (rd_ff > val_ff);
   assign stat.idx_ok   = (32'(idx_ff) < 32'(cnt_ff));

   assign rsp_item.read_value   = 16'(rv_ff);
   assign rsp_item.stored_count = 9'(cnt_ff);
   assign rsp_item.status       = status_ff;

endmodule

// ===== hdl/insertion_sorter_core.sv =====
// Online insertion sorter. Assert start with a request while busy is low; the request is taken
// at that clock edge and busy stays high until its single response has been shown. An insert
// command places its value into an ascending store, after any equal values already held, by
// shifting larger entries up one place; a read command returns the entry at the given index of
// the ascending order; a clear command empties the store. Every request yields one response on
// rsp_item, marked by rsp_valid for exactly one cycle, and the receiver cannot stall it. The
// shift of an insert runs down through the store from its top entry at one entry per cycle,
// until it meets an entry that is not greater than the new value; after each response the
// sorter returns to idle before the next request is taken. An insert into a full store is
// dropped with status 1, and a read at or beyond the stored count returns 0 with status 2.
module insertion_sorter_core
   import isort_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int VALUE_BITS = 16
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  isort_req_type req_item,
   output logic          rsp_valid,
   output isort_rsp_type rsp_item
);

   isort_cmd_type  cmd;
   isort_stat_type stat;

   isort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   isort_dp #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("Response strobe seen while the sorter is idle.");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("Response strobe in the cycle after a transaction was taken.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Response strobe lasted more than one cycle.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STATUS_FULL) |-> (rsp_item.stored_count == 9'(DEPTH)))
      else $error("Insert dropped as full while the store was not full.");

endmodule
